[rtl/vlsm_pkg.sv]
// shared constants, codes and control structs of the subnet allocator
`timescale 1ns / 1ps

package vlsm_pkg;

  localparam int MAX_REQUESTS   = 16;
  localparam int IDX_W          = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int LOAD_W         = $clog2(MAX_REQUESTS + 1);
  localparam int COUNT_W        = 30;
  localparam int HOST_BITS_MAX  = 30;
  localparam int HB_W           = 5;
  localparam int ADDR_W         = 32;
  localparam int PFX_W          = 6;
  localparam int RIDX_W         = 6;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 32;
  localparam int PREFIX_RESET   = 24;

  localparam logic [CFG_IDX_W-1:0] REG_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX = 2'd1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_TOO_MANY  = 2'd3
  } status_t;

  typedef struct packed {
    logic accept;
    logic clear;
    logic start;
    logic ld_err;
    logic rd_i;
    logic cap_i;
    logic eval_j;
    logic wr_rank;
    logic ld_res;
    logic next_item;
  } cmd_t;

  typedef struct packed {
    logic batch_err;
    logic i_last;
    logic j_last;
    logic res_last;
  } stat_t;

endpackage

[rtl/vlsm_if.sv]
// request and result channel interfaces
`timescale 1ns / 1ps

interface vlsm_req_if import vlsm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] station_count;
  logic               last_request;

  modport source(output valid, station_count, last_request, input ready);
  modport sink(input valid, station_count, last_request, output ready);
endinterface

interface vlsm_res_if import vlsm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RIDX_W-1:0] request_index;
  logic [ADDR_W-1:0] assigned_address;
  logic [PFX_W-1:0]  subnet_prefix;
  logic [1:0]        status;
  logic              last_result;

  modport source(output valid, request_index, assigned_address, subnet_prefix, status,
                 last_result, input ready);
  modport sink(input valid, request_index, assigned_address, subnet_prefix, status,
               last_result, output ready);
endinterface

[rtl/vlsm_ctrl.sv]
// controller state machine: load, rank sort and result sequencing
`timescale 1ns / 1ps

module vlsm_ctrl import vlsm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  input  logic  req_last,
  output logic  req_ready,
  output logic  res_valid,
  input  logic  res_ready,
  output cmd_t  cmd,
  input  stat_t stat
);

  typedef enum logic [10:0] {
    S_LOAD    = 11'b000_0000_0001,
    S_START   = 11'b000_0000_0010,
    S_SORT_RI = 11'b000_0000_0100,
    S_SORT_CI = 11'b000_0000_1000,
    S_SORT_RJ = 11'b000_0001_0000,
    S_SORT_EJ = 11'b000_0010_0000,
    S_SORT_WR = 11'b000_0100_0000,
    S_EMIT_RO = 11'b000_1000_0000,
    S_EMIT_RH = 11'b001_0000_0000,
    S_EMIT_C  = 11'b010_0000_0000,
    S_EMIT_O  = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:    if (req_valid && req_last) state_next = S_START;
      S_START:   state_next = stat.batch_err ? S_EMIT_O : S_SORT_RI;
      S_SORT_RI: state_next = S_SORT_CI;
      S_SORT_CI: state_next = S_SORT_RJ;
      S_SORT_RJ: state_next = S_SORT_EJ;
      S_SORT_EJ: state_next = stat.j_last ? S_SORT_WR : S_SORT_RJ;
      S_SORT_WR: state_next = stat.i_last ? S_EMIT_RO : S_SORT_RI;
      S_EMIT_RO: state_next = S_EMIT_RH;
      S_EMIT_RH: state_next = S_EMIT_C;
      S_EMIT_C:  state_next = S_EMIT_O;
      S_EMIT_O: begin
        if (res_ready) state_next = stat.res_last ? S_LOAD : S_EMIT_RO;
      end
      default:   state_next = S_LOAD;
    endcase
  end

  assign req_ready = (state == S_LOAD);
  assign res_valid = (state == S_EMIT_O);

  always_comb begin
    cmd           = '0;
    cmd.accept    = (state == S_LOAD) && req_valid;
    cmd.start     = (state == S_START);
    cmd.ld_err    = (state == S_START) && stat.batch_err;
    cmd.rd_i      = (state == S_SORT_RI);
    cmd.cap_i     = (state == S_SORT_CI);
    cmd.eval_j    = (state == S_SORT_EJ);
    cmd.wr_rank   = (state == S_SORT_WR);
    cmd.ld_res    = (state == S_EMIT_C);
    cmd.next_item = (state == S_EMIT_O) && res_ready && !stat.res_last;
    cmd.clear     = (state == S_EMIT_O) && res_ready && stat.res_last;
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && res_valid))
    else $error("request and result sides open together");

  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_last) |=> (state == S_START))
    else $error("last request did not start allocation");

  a_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("controller state not one-hot");

endmodule

[rtl/vlsm_dp.sv]
// datapath: request stores, rank sort, offset cursor and result register
`timescale 1ns / 1ps

module vlsm_dp import vlsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [COUNT_W-1:0]    station_count,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  output logic [RIDX_W-1:0]     request_index,
  output logic [ADDR_W-1:0]     assigned_address,
  output logic [PFX_W-1:0]      subnet_prefix,
  output status_t               status,
  output logic                  last_result
);

  localparam int COUNT_W1 = COUNT_W + 1;

  function automatic logic [HB_W-1:0] host_bits_for(input logic [COUNT_W-1:0] count);
    logic [COUNT_W1-1:0] v;
    logic [HB_W-1:0]     h;
    // bit length of count + 1, held at the largest host field
    v = {1'b0, count} + COUNT_W1'(1);
    h = HB_W'(1);
    for (int k = 1; k < COUNT_W; k++) begin
      if (v[k]) h = HB_W'(k + 1);
    end
    if (v[COUNT_W]) h = HB_W'(HOST_BITS_MAX);
    return h;
  endfunction

  logic [COUNT_W-1:0] count_mem [MAX_REQUESTS];
  logic [HB_W-1:0]    hb_mem    [MAX_REQUESTS];
  logic [IDX_W-1:0]   ord_mem   [MAX_REQUESTS];

  logic [COUNT_W-1:0] cnt_rdata;
  logic [HB_W-1:0]    hb_rdata;
  logic [IDX_W-1:0]   ord_rdata;
  logic [IDX_W-1:0]   cnt_raddr;

  logic [ADDR_W-1:0]  base;
  logic [PFX_W-1:0]   prefix;
  logic [LOAD_W-1:0]  loaded;
  logic [ADDR_W:0]    cursor;
  logic [ADDR_W:0]    sum_q;
  status_t            err;
  logic [IDX_W-1:0]   err_idx;

  logic [IDX_W-1:0]   i, j, rank;
  logic [COUNT_W-1:0] ci;

  logic               has_room;
  logic               too_large;
  logic [LOAD_W-1:0]  last_pos;
  logic [ADDR_W:0]    space;
  logic [ADDR_W:0]    sum;
  logic               fits;
  logic               beats_i;

  assign has_room  = loaded < LOAD_W'(MAX_REQUESTS);
  assign too_large = &station_count;
  assign last_pos  = loaded - LOAD_W'(1);
  assign cnt_raddr = cmd.rd_i ? i : j;

  // block size of the base network, a single address for oversized prefixes
  assign space = (prefix >= PFX_W'(ADDR_W)) ? (ADDR_W+1)'(1)
                                           : ((ADDR_W+1)'(1) << (PFX_W'(ADDR_W) - prefix));
  assign sum   = cursor + ((ADDR_W+1)'(1) << hb_rdata);
  assign fits  = (sum <= space);

  // stable descending order: larger count, or equal count that arrived earlier
  assign beats_i = (cnt_rdata > ci) || ((cnt_rdata == ci) && (j < i));

  assign stat.batch_err = (err != ST_OK);
  assign stat.i_last    = ({1'b0, i} == last_pos);
  assign stat.j_last    = ({1'b0, j} == last_pos);
  assign stat.res_last  = last_result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base   <= '0;
      prefix <= PFX_W'(PREFIX_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE:   base   <= cfg_data[ADDR_W-1:0];
        REG_PREFIX: prefix <= cfg_data[PFX_W-1:0];
        default:    ;
      endcase
    end
  end

  // stores, written and read with registered data
  always_ff @(posedge clk) begin
    if (cmd.accept && has_room) begin
      count_mem[loaded[IDX_W-1:0]] <= station_count;
      hb_mem[loaded[IDX_W-1:0]]    <= host_bits_for(station_count);
    end
    if (cmd.wr_rank) begin
      ord_mem[rank] <= i;
    end
    cnt_rdata <= count_mem[cnt_raddr];
    ord_rdata <= ord_mem[i];
    hb_rdata  <= hb_mem[ord_rdata];
  end

  // batch state
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
      cursor <= '0;
      err    <= ST_OK;
    end else if (cmd.clear) begin
      loaded <= '0;
      cursor <= '0;
      err    <= ST_OK;
    end else begin
      if (cmd.accept) begin
        if (has_room) begin
          loaded <= loaded + LOAD_W'(1);
          if (too_large && err == ST_OK) err <= ST_TOO_LARGE;
        end else if (err == ST_OK) begin
          err <= ST_TOO_MANY;
        end
      end
      if (cmd.next_item) cursor <= sum_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && has_room && too_large && err == ST_OK) begin
      err_idx <= loaded[IDX_W-1:0];
    end
  end

  // sort and emit counters
  always_ff @(posedge clk) begin
    if (cmd.start) i <= '0;
    if (cmd.cap_i) begin
      ci   <= cnt_rdata;
      j    <= '0;
      rank <= '0;
    end
    if (cmd.eval_j) begin
      if (beats_i) rank <= rank + IDX_W'(1);
      j <= j + IDX_W'(1);
    end
    if (cmd.wr_rank) i <= stat.i_last ? '0 : i + IDX_W'(1);
    if (cmd.next_item) i <= i + IDX_W'(1);
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      last_result <= 1'b0;
    end else if (cmd.ld_err) begin
      last_result <= 1'b1;
    end else if (cmd.ld_res) begin
      last_result <= !fits || stat.i_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_err) begin
      request_index    <= (err == ST_TOO_LARGE) ? RIDX_W'(err_idx) : '0;
      assigned_address <= '0;
      subnet_prefix    <= '0;
      status           <= err;
    end else if (cmd.ld_res) begin
      request_index    <= RIDX_W'(ord_rdata);
      assigned_address <= fits ? (base | cursor[ADDR_W-1:0]) : '0;
      subnet_prefix    <= PFX_W'(ADDR_W) - PFX_W'(hb_rdata);
      status           <= fits ? ST_OK : ST_NO_SPACE;
      sum_q            <= sum;
    end
  end

  a_load_bound: assert property (@(posedge clk) disable iff (rst)
    loaded <= LOAD_W'(MAX_REQUESTS))
    else $error("request count past store depth");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (loaded == '0) && (cursor == '0) && (err == ST_OK))
    else $error("batch not cleared after final item");

  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    cursor <= {1'b1, {ADDR_W{1'b0}}})
    else $error("offset cursor beyond address space");

endmodule

[rtl/vlsm_subnet_allocator.sv]
// top level: vlsm subnet allocator
// requests load one item per cycle while loading, no result until the last request of a batch
// error batch: one result item, loaded in the start state after the last request
// otherwise the rank sort runs over the n stored requests (one count store read per cycle),
// then each result item passes the read, hold and capture states after the previous is taken
// synchronous reset clears the batch, base_address to 0 and prefix_length to 24
`timescale 1ns / 1ps

module vlsm_subnet_allocator import vlsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  vlsm_req_if.sink              req,
  vlsm_res_if.source            res
);

  cmd_t    cmd;
  stat_t   stat;
  status_t res_status;

  vlsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_last  (req.last_request),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  vlsm_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .station_count    (req.station_count),
    .cmd              (cmd),
    .stat             (stat),
    .request_index    (res.request_index),
    .assigned_address (res.assigned_address),
    .subnet_prefix    (res.subnet_prefix),
    .status           (res_status),
    .last_result      (res.last_result)
  );

  assign res.status = res_status;

endmodule

[sim/vlsm_subnet_allocator_tb.sv]
// self-checking testbench for the vlsm subnet allocator
`timescale 1ns / 1ps

module vlsm_subnet_allocator_tb import vlsm_pkg::*; ();

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [COUNT_W-1:0]   COUNT_CAP   = 30'h3FFF_FFFE;
  localparam logic [COUNT_W-1:0]   COUNT_HUGE  = 30'h3FFF_FFFF;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT   = 300000;

  typedef logic [COUNT_W-1:0] count_q_t[$];

  typedef struct packed {
    logic [RIDX_W-1:0] request_index;
    logic [ADDR_W-1:0] assigned_address;
    logic [PFX_W-1:0]  subnet_prefix;
    status_t           status;
    logic              last_result;
  } subnet_grant_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  vlsm_req_if req_ch ();
  vlsm_res_if res_ch ();

  vlsm_subnet_allocator DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .res       (res_ch)
  );

  // allocator shadow state
  logic [ADDR_W-1:0]  base_reg   = '0;
  logic [PFX_W-1:0]   prefix_reg = PFX_W'(PREFIX_RESET);
  logic [COUNT_W-1:0] held_count [MAX_REQUESTS];
  int unsigned        held_hbits [MAX_REQUESTS];
  int unsigned        held        = 0;
  status_t            batch_fault = ST_OK;

  subnet_grant_t expected_subnets[$];

  int unsigned source_gap_pct  = 0;
  int unsigned sink_stall_pct  = 0;
  int unsigned mismatch_count  = 0;
  int unsigned results_checked = 0;
  int unsigned requests_sent   = 0;
  int unsigned batches_sent    = 0;
  int unsigned reg_writes      = 0;
  int unsigned cycle_count     = 0;
  int unsigned status_hits [4] = '{0, 0, 0, 0};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_subnets.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) res_ch.ready <= 1'b0;
    else res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch in %s at result %0d: got 0x%0h, expected 0x%0h", what,
               results_checked, got, want);
  endtask

  always @(posedge clk) begin
    subnet_grant_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_checked++;
      if (expected_subnets.size() == 0) begin
        report_mismatch("unexpected result item", res_ch.request_index, 0);
      end else begin
        want = expected_subnets.pop_front();
        status_hits[want.status]++;
        if (res_ch.request_index !== want.request_index)
          report_mismatch("request_index", res_ch.request_index, want.request_index);
        if (res_ch.assigned_address !== want.assigned_address)
          report_mismatch("assigned_address", res_ch.assigned_address, want.assigned_address);
        if (res_ch.subnet_prefix !== want.subnet_prefix)
          report_mismatch("subnet_prefix", res_ch.subnet_prefix, want.subnet_prefix);
        if (res_ch.status !== want.status)
          report_mismatch("status", res_ch.status, want.status);
        if (res_ch.last_result !== want.last_result)
          report_mismatch("last_result", res_ch.last_result, want.last_result);
      end
    end
  end

  function automatic int unsigned host_bits_needed(input logic [COUNT_W-1:0] cnt);
    for (int unsigned hb = 1; hb <= HOST_BITS_MAX; hb++)
      if ((64'd1 << hb) - 64'd2 >= 64'(cnt)) return hb;
    return HOST_BITS_MAX;
  endfunction

  // stable sort by count, largest first, then carve aligned blocks from offset 0
  task automatic allocate_batch();
    int unsigned   order [MAX_REQUESTS];
    int unsigned   j, pick, hb;
    logic [32:0]   cursor, space, span;
    subnet_grant_t g;
    g = '0;
    if (batch_fault == ST_TOO_MANY) begin
      g.status = ST_TOO_MANY;
      g.last_result = 1'b1;
      expected_subnets.push_back(g);
    end else if (batch_fault == ST_TOO_LARGE) begin
      pick = held;
      for (int unsigned i = 0; i < held; i++)
        if (pick == held && held_count[i] > COUNT_CAP) pick = i;
      g.request_index = RIDX_W'(pick);
      g.status = ST_TOO_LARGE;
      g.last_result = 1'b1;
      expected_subnets.push_back(g);
    end else begin
      space = (prefix_reg >= 32) ? 33'd1 : (33'd1 << (32 - prefix_reg));
      for (int unsigned i = 0; i < held; i++) begin
        j = i;
        while (j > 0 && held_count[order[j-1]] < held_count[i]) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = i;
      end
      cursor = '0;
      for (int unsigned k = 0; k < held; k++) begin
        pick = order[k];
        hb = held_hbits[pick];
        span = 33'd1 << hb;
        g.request_index = RIDX_W'(pick);
        g.subnet_prefix = PFX_W'(32 - hb);
        if (cursor + span > space) begin
          g.assigned_address = '0;
          g.status = ST_NO_SPACE;
          g.last_result = 1'b1;
          expected_subnets.push_back(g);
          break;
        end
        g.assigned_address = base_reg | cursor[31:0];
        g.status = ST_OK;
        g.last_result = (k == held - 1);
        expected_subnets.push_back(g);
        cursor = cursor + span;
      end
    end
  endtask

  task automatic track_request(input logic [COUNT_W-1:0] cnt, input logic lst);
    if (held < MAX_REQUESTS) begin
      held_count[held] = cnt;
      held_hbits[held] = host_bits_needed(cnt);
      if (cnt > COUNT_CAP && batch_fault == ST_OK) batch_fault = ST_TOO_LARGE;
      held++;
    end else if (batch_fault == ST_OK) begin
      // request dropped, store already full
      batch_fault = ST_TOO_MANY;
    end
    if (lst) begin
      allocate_batch();
      held = 0;
      batch_fault = ST_OK;
    end
  endtask

  task automatic send_request(input logic [COUNT_W-1:0] cnt, input logic lst);
    while ($urandom_range(99) < source_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.station_count <= cnt;
    req_ch.last_request  <= lst;
    do @(posedge clk); while (!req_ch.ready);
    requests_sent++;
    track_request(cnt, lst);
  endtask

  task automatic send_batch(input count_q_t counts);
    foreach (counts[i]) send_request(counts[i], i == counts.size() - 1);
    batches_sent++;
  endtask

  // sender holds off until every expected item is back and the block has settled
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (expected_subnets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_BASE) base_reg = data;
    else if (idx == REG_PREFIX) prefix_reg = data[PFX_W-1:0];
    reg_writes++;
  endtask

  function automatic logic [COUNT_W-1:0] random_count(input int unsigned hb);
    longint unsigned lo, hi;
    lo = (hb == 1) ? 0 : (64'd1 << (hb - 1)) - 1;
    hi = (64'd1 << hb) - 2;
    case ($urandom_range(3))
      0: begin
        return COUNT_W'(lo);
      end
      1: begin
        return COUNT_W'(hi);
      end
      default: begin
        return COUNT_W'(lo + (longint'($urandom) % (hi - lo + 1)));
      end
    endcase
  endfunction

  task automatic randomise_config();
    logic [CFG_DATA_W-1:0] b;
    int unsigned           p;
    case ($urandom_range(3))
      0: begin
        b = '0;
      end
      1: begin
        b = '1;
      end
      default: begin
        b = $urandom;
      end
    endcase
    case ($urandom_range(7))
      0: begin
        p = 0;
      end
      1: begin
        p = 32;
      end
      2: begin
        p = $urandom_range(33, 63);
      end
      3: begin
        p = $urandom_range(1, 15);
      end
      default: begin
        p = $urandom_range(16, 30);
      end
    endcase
    write_reg(REG_BASE, b);
    write_reg(REG_PREFIX, p);
    if ($urandom_range(3) == 0) write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
  endtask

  task automatic test_reset_defaults();
    count_q_t counts;
    counts = '{30'd1, 30'd62, 30'd0, 30'd62};
    send_batch(counts);
    drain_results();
  endtask

  task automatic test_spare_registers();
    count_q_t counts;
    write_reg(REG_BASE, 32'h0A00_0000);
    write_reg(REG_PREFIX, 32'd30);
    // these must leave base and prefix alone
    write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_B, 32'd33);
    counts = '{30'd2};
    send_batch(counts);
    drain_results();
  endtask

  task automatic test_space_exhaustion();
    count_q_t counts;
    write_reg(REG_BASE, 32'hFFFF_FFFF);
    write_reg(REG_PREFIX, 32'd0);
    // four largest blocks fill the whole space exactly, the smallest one misses
    counts = '{COUNT_CAP, COUNT_CAP, 30'd0, 30'h2000_0000, COUNT_CAP};
    send_batch(counts);
    drain_results();
  endtask

  task automatic test_oversized_prefix();
    count_q_t counts;
    write_reg(REG_BASE, 32'hC0A8_0100);
    write_reg(REG_PREFIX, 32'h68);
    counts = '{30'd0};
    send_batch(counts);
    drain_results();
    write_reg(REG_PREFIX, 32'd32);
    send_batch(counts);
    drain_results();
  endtask

  task automatic test_count_too_large();
    count_q_t counts;
    write_reg(REG_PREFIX, 32'd24);
    counts = '{30'd3, COUNT_HUGE};
    send_batch(counts);
    drain_results();
  endtask

  task automatic test_too_many_requests();
    count_q_t counts;
    counts = {};
    for (int unsigned i = 0; i <= MAX_REQUESTS; i++) counts.push_back(COUNT_W'(i));
    send_batch(counts);
    drain_results();
  endtask

  task automatic test_random_batches(input int unsigned gap_pct, input int unsigned stall_pct,
                                     input int unsigned quota);
    count_q_t    counts;
    int unsigned stored, size, kind, hb, room, top, low_top;
    source_gap_pct = gap_pct;
    sink_stall_pct = stall_pct;
    stored = 0;
    while (stored < quota) begin
      if ($urandom_range(3) == 0) begin
        drain_results();
        randomise_config();
      end
      kind = $urandom_range(99);
      room = (prefix_reg >= 32) ? 0 : 32 - prefix_reg;
      top = (room > HOST_BITS_MAX) ? HOST_BITS_MAX : ((room < 1) ? 1 : room);
      low_top = (top > 3) ? top - 3 : 1;
      if (kind >= 90) size = $urandom_range(MAX_REQUESTS + 1, MAX_REQUESTS + 4);
      else if ($urandom_range(9) == 0) size = $urandom_range(7, MAX_REQUESTS);
      else size = $urandom_range(1, 6);
      counts = {};
      for (int unsigned i = 0; i < size; i++) begin
        if (i > 0 && $urandom_range(4) == 0) begin
          // equal counts, order must follow arrival
          counts.push_back(counts[i-1]);
        end else begin
          if (kind >= 65 && kind < 80) hb = $urandom_range(low_top, top);
          else hb = $urandom_range(1, low_top);
          counts.push_back(random_count(hb));
        end
      end
      if ((kind >= 80 && kind < 90) || (kind >= 90 && $urandom_range(1) == 0)) begin
        counts[$urandom_range(0, size - 1)] = COUNT_HUGE;
        if ($urandom_range(1) == 0) counts[$urandom_range(0, size - 1)] = COUNT_HUGE;
      end
      send_batch(counts);
      stored += (size > MAX_REQUESTS) ? MAX_REQUESTS : size;
    end
    drain_results();
  endtask

  initial begin
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= REG_BASE;
    cfg_data             <= '0;
    req_ch.valid         <= 1'b0;
    req_ch.station_count <= '0;
    req_ch.last_request  <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_spare_registers();
    test_space_exhaustion();
    test_oversized_prefix();
    test_count_too_large();
    test_too_many_requests();
    test_random_batches(27, 50, 50);
    test_random_batches(50, 27, 50);
    test_random_batches(0, 0, 50);

    if (expected_subnets.size() != 0)
      report_mismatch("results never returned", 0, expected_subnets.size());
    $display("sent %0d requests in %0d batches with %0d register writes, checked %0d results",
             requests_sent, batches_sent, reg_writes, results_checked);
    $display("status seen: ok %0d, no space %0d, count too large %0d, too many %0d",
             status_hits[ST_OK], status_hits[ST_NO_SPACE], status_hits[ST_TOO_LARGE],
             status_hits[ST_TOO_MANY]);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/vlsm_pkg.sv
rtl/vlsm_if.sv
rtl/vlsm_ctrl.sv
rtl/vlsm_dp.sv
rtl/vlsm_subnet_allocator.sv
sim/vlsm_subnet_allocator_tb.sv
